>>> hdl/shadow_memory_taint_tracker_macros.svh
// Assertion macros used by the shadow memory taint tracker top level.
`ifndef SHADOW_MEMORY_TAINT_TRACKER_MACROS_SVH
`define SHADOW_MEMORY_TAINT_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define SMTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smtt assertion failed");
`define SMTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smtt assertion failed");
`else
`define SMTT_ASSERT_IMP(lbl, ante, cons)
`define SMTT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hdl/smtt_pkg.sv
// Package with shared constants, codes and types of the shadow memory taint tracker.
`default_nettype none
package smtt_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int PAGE_SLOTS_DEF = 16;
  localparam int MAX_RANGE_DEF  = 4096;
  localparam int MAX_EVENTS_DEF = 256;

  localparam int CMD_W    = 3;
  localparam int TAG_W    = 7;
  localparam int IN_TDATA_W  = 312;
  localparam int IN_TUSER_W  = 7;
  localparam int OUT_TDATA_W = 296;
  localparam int OUT_TUSER_W = 4;

  localparam logic [CMD_W-1:0] CMD_MARK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PROP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SINK  = 3'd4;

  typedef enum logic [4:0] {
    ST_WIPE, ST_IDLE, ST_DISPATCH, ST_DROP, ST_SW_CHECK, ST_SW_NEXT, ST_Q_RD, ST_Q_ACC,
    ST_C_WR, ST_C_SRD, ST_C_SCHK, ST_C_FREE, ST_S_EVT, ST_CH_START, ST_CH_END,
    ST_SEARCH_S, ST_SEARCH_D, ST_M_TAKE, ST_M_RD, ST_M_WR, ST_P_SRCHK, ST_P_HRD,
    ST_P_HCHK, ST_P_DTAKE, ST_P_CRS, ST_P_CRD, ST_P_CWR, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_WIPE, OP_LOAD, OP_PREP, OP_DROP, OP_SLOT_NEXT, OP_SW_START, OP_RD_SW,
    OP_ACC, OP_WR_ZERO, OP_KINC, OP_FREE, OP_EVENT, OP_CHUNK, OP_CHUNK_END,
    OP_SEARCH_INIT, OP_SEARCH_SRC, OP_SEARCH_DST, OP_TAKE_SRC, OP_TAKE_DST, OP_RD_SRC,
    OP_RD_DST, OP_WR_MARK, OP_WR_PROP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic size_big;
    logic tag_zero;
    logic dst_ovf;
    logic src_ovf;
    logic wipe_last;
    logic slot_last;
    logic slot_hit;
    logic k_hi;
    logic k_end;
    logic k_clast;
    logic rd_nz;
    logic union_nz;
    logic ev_room;
    logic rem_zero;
    logic avail;
    logic found;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

>>> hdl/smtt_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module smtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/smtt_ctrl.sv
// Controller state machine that sequences commands over the tracker datapath.
`default_nettype none
module smtt_ctrl import smtt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t st,
  output dp_op_t          op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_WIPE: begin
        op = OP_WIPE;
        if (st.wipe_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        op = OP_PREP;
        unique case (st.cmd)
          CMD_MARK: begin
            if (st.rem_zero || st.tag_zero || st.size_big) state_next = ST_FIN;
            else if (st.dst_ovf) state_next = ST_DROP;
            else state_next = ST_CH_START;
          end
          CMD_CLEAR: begin
            if (st.rem_zero) state_next = ST_FIN;
            else if (st.dst_ovf) state_next = ST_DROP;
            else state_next = ST_SW_CHECK;
          end
          CMD_QUERY: begin
            if (st.rem_zero || st.dst_ovf) state_next = ST_FIN;
            else state_next = ST_SW_CHECK;
          end
          CMD_PROP: begin
            if (st.rem_zero || st.size_big) state_next = ST_FIN;
            else if (st.src_ovf || st.dst_ovf) state_next = ST_DROP;
            else state_next = ST_SW_CHECK;
          end
          CMD_SINK: begin
            if (st.rem_zero || st.size_big) state_next = ST_FIN;
            else if (st.dst_ovf) state_next = ST_DROP;
            else state_next = ST_SW_CHECK;
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_DROP: begin
        op         = OP_DROP;
        state_next = ST_FIN;
      end
      ST_SW_CHECK: begin
        if (st.slot_hit) begin
          if (st.cmd == CMD_PROP) begin
            state_next = ST_CH_START;
          end else begin
            op         = OP_SW_START;
            state_next = (st.cmd == CMD_CLEAR) ? ST_C_WR : ST_Q_RD;
          end
        end else begin
          state_next = ST_SW_NEXT;
        end
      end
      ST_SW_NEXT: begin
        if (st.slot_last) begin
          state_next = (st.cmd == CMD_SINK) ? ST_S_EVT : ST_FIN;
        end else begin
          op         = OP_SLOT_NEXT;
          state_next = ST_SW_CHECK;
        end
      end
      ST_Q_RD: begin
        op         = OP_RD_SW;
        state_next = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        op         = OP_ACC;
        state_next = st.k_hi ? ST_SW_NEXT : ST_Q_RD;
      end
      ST_C_WR: begin
        op = OP_WR_ZERO;
        if (st.k_hi) state_next = ST_C_SRD;
      end
      ST_C_SRD: begin
        op         = OP_RD_SW;
        state_next = ST_C_SCHK;
      end
      ST_C_SCHK: begin
        if (st.rd_nz) begin
          state_next = ST_SW_NEXT;
        end else if (st.k_end) begin
          state_next = ST_C_FREE;
        end else begin
          op         = OP_KINC;
          state_next = ST_C_SRD;
        end
      end
      ST_C_FREE: begin
        op         = OP_FREE;
        state_next = ST_SW_NEXT;
      end
      ST_S_EVT: begin
        if (st.union_nz) op = st.ev_room ? OP_EVENT : OP_DROP;
        state_next = ST_FIN;
      end
      ST_CH_START: begin
        if (st.rem_zero) begin
          state_next = ST_FIN;
        end else begin
          op         = OP_CHUNK;
          state_next = (st.cmd == CMD_MARK) ? ST_SEARCH_D : ST_SEARCH_S;
        end
      end
      ST_CH_END: begin
        op         = OP_CHUNK_END;
        state_next = ST_CH_START;
      end
      ST_SEARCH_S: begin
        op = OP_SEARCH_SRC;
        if (st.slot_last) state_next = ST_P_SRCHK;
      end
      ST_SEARCH_D: begin
        op = OP_SEARCH_DST;
        if (st.slot_last) state_next = (st.cmd == CMD_MARK) ? ST_M_TAKE : ST_P_DTAKE;
      end
      ST_M_TAKE: begin
        if (st.avail) begin
          op         = OP_TAKE_DST;
          state_next = ST_M_RD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_M_RD: begin
        op         = OP_RD_DST;
        state_next = ST_M_WR;
      end
      ST_M_WR: begin
        op         = OP_WR_MARK;
        state_next = st.k_clast ? ST_CH_END : ST_M_RD;
      end
      ST_P_SRCHK: begin
        if (st.found) begin
          op         = OP_TAKE_SRC;
          state_next = ST_P_HRD;
        end else begin
          state_next = ST_CH_END;
        end
      end
      ST_P_HRD: begin
        op         = OP_RD_SRC;
        state_next = ST_P_HCHK;
      end
      ST_P_HCHK: begin
        if (st.rd_nz) begin
          op         = OP_SEARCH_INIT;
          state_next = ST_SEARCH_D;
        end else if (st.k_clast) begin
          state_next = ST_CH_END;
        end else begin
          op         = OP_KINC;
          state_next = ST_P_HRD;
        end
      end
      ST_P_DTAKE: begin
        if (st.avail) begin
          op         = OP_TAKE_DST;
          state_next = ST_P_CRS;
        end else begin
          state_next = ST_CH_END;
        end
      end
      ST_P_CRS: begin
        op         = OP_RD_SRC;
        state_next = ST_P_CRD;
      end
      ST_P_CRD: begin
        op         = OP_RD_DST;
        state_next = ST_P_CWR;
      end
      ST_P_CWR: begin
        op         = OP_WR_PROP;
        state_next = st.k_clast ? ST_CH_END : ST_P_CRS;
      end
      ST_FIN: begin
        if (!st.out_busy) begin
          op         = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/smtt_dpath.sv
// Datapath of the tracker: page slots, tag memory, counters and the result register.
`default_nettype none
module smtt_dpath import smtt_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
  parameter int MAX_RANGE  = MAX_RANGE_DEF,
  parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dp_op_t                 op,
  output dp_status_t                  st,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic      [OUT_TUSER_W-1:0] out_tuser
);

  localparam int OFFW = $clog2(PAGE_BYTES);
  localparam int PNW  = 64 - OFFW;
  localparam int SW   = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int AW   = SW + OFFW;
  localparam int PCW  = $clog2(PAGE_SLOTS + 1);
  localparam int ECW  = $clog2(MAX_EVENTS + 1);

  logic [CMD_W-1:0] cmd_r;
  logic [63:0]      da, sa, dst_end, src_end, dst_last, src_last;
  logic             dst_ovf, src_ovf;
  logic [31:0]      rem;
  logic [TAG_W-1:0] tag_r, uni, sbyte;
  logic [63:0]      sink_addr_r, instr_r;
  logic [15:0]      thread_r;
  logic [3:0]       kind_r;
  logic             ev_valid;

  logic             slot_valid [PAGE_SLOTS];
  logic [PNW-1:0]   slot_page  [PAGE_SLOTS];

  logic [SW-1:0]    si, fidx, freeidx, sp, dp;
  logic [OFFW-1:0]  k, hi, clm1;
  logic [OFFW:0]    clen;
  logic             found, free_ok;
  logic [PCW-1:0]   pages;
  logic [ECW-1:0]   events;
  logic [63:0]      drops;
  logic [AW-1:0]    wipe;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [TAG_W-1:0] ram_wdata, rdata;

  logic [63:0]      rstart, rlast, pb, ptop;
  logic [OFFW-1:0]  lo_c, hi_c;
  logic [PNW-1:0]   key;
  logic [OFFW:0]    dfree, sfree, cmin, clen_c;
  logic [AW-1:0]    sw_addr, src_ra, dst_ra;

  assign rstart = (cmd_r == CMD_PROP) ? sa : da;
  assign rlast  = (cmd_r == CMD_PROP) ? src_last : dst_last;
  assign pb     = {slot_page[si], {OFFW{1'b0}}};
  assign ptop   = {slot_page[si], {OFFW{1'b1}}};
  assign lo_c   = (rstart > pb) ? rstart[OFFW-1:0] : '0;
  assign hi_c   = (rlast < ptop) ? rlast[OFFW-1:0] : '1;
  assign key    = (op == OP_SEARCH_SRC) ? sa[63:OFFW] : da[63:OFFW];

  assign dfree  = (OFFW+1)'(PAGE_BYTES) - {1'b0, da[OFFW-1:0]};
  assign sfree  = (OFFW+1)'(PAGE_BYTES) - {1'b0, sa[OFFW-1:0]};
  assign cmin   = (cmd_r == CMD_PROP && sfree < dfree) ? sfree : dfree;
  assign clen_c = (rem < 32'(cmin)) ? rem[OFFW:0] : cmin;

  assign sw_addr = {si, k};
  assign src_ra  = {sp, sa[OFFW-1:0] + k};
  assign dst_ra  = {dp, da[OFFW-1:0] + k};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sw_addr;
    ram_wdata = '0;
    case (op)
      OP_WIPE:    begin ram_we = 1'b1; ram_waddr = wipe; end
      OP_WR_ZERO: begin ram_we = 1'b1; ram_waddr = sw_addr; end
      OP_WR_MARK: begin ram_we = 1'b1; ram_waddr = dst_ra; ram_wdata = rdata | tag_r; end
      OP_WR_PROP: begin ram_we = 1'b1; ram_waddr = dst_ra; ram_wdata = rdata | sbyte; end
      default: ;
    endcase
    case (op)
      OP_RD_SRC: ram_raddr = src_ra;
      OP_RD_DST: ram_raddr = dst_ra;
      default:   ram_raddr = sw_addr;
    endcase
  end

  smtt_ram #(.WIDTH(TAG_W), .DEPTH(2 ** AW)) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_comb begin
    st.cmd       = cmd_r;
    st.size_big  = rem > 32'(MAX_RANGE);
    st.tag_zero  = tag_r == '0;
    st.dst_ovf   = dst_ovf;
    st.src_ovf   = src_ovf;
    st.wipe_last = &wipe;
    st.slot_last = si == SW'(PAGE_SLOTS - 1);
    st.slot_hit  = slot_valid[si] && !(pb > rlast) && !(rstart > ptop);
    st.k_hi      = k == hi;
    st.k_end     = &k;
    st.k_clast   = k == clm1;
    st.rd_nz     = rdata != '0;
    st.union_nz  = uni != '0;
    st.ev_room   = events < ECW'(MAX_EVENTS);
    st.rem_zero  = rem == '0;
    st.avail     = found || free_ok;
    st.found     = found;
    st.out_busy  = out_tvalid && !out_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_SLOTS; i++) slot_valid[i] <= 1'b0;
      pages      <= '0;
      events     <= '0;
      drops      <= '0;
      out_tvalid <= 1'b0;
      wipe       <= '0;
    end else begin
      if (out_tvalid && out_tready && op != OP_OUT) out_tvalid <= 1'b0;
      case (op)
        OP_WIPE:  wipe <= wipe + 1'b1;
        OP_DROP:  if (drops != '1) drops <= drops + 64'd1;
        OP_FREE: begin
          slot_valid[si] <= 1'b0;
          pages          <= pages - 1'b1;
        end
        OP_EVENT: events <= events + 1'b1;
        OP_TAKE_DST: begin
          if (!found && free_ok) begin
            slot_valid[freeidx] <= 1'b1;
            pages               <= pages + 1'b1;
          end
        end
        OP_OUT:   out_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd_r               <= in_tuser[2:0];
        da                  <= in_tdata[63:0];
        sa                  <= in_tdata[127:64];
        rem                 <= in_tdata[159:128];
        tag_r               <= in_tdata[166:160];
        sink_addr_r         <= in_tdata[230:167];
        instr_r             <= in_tdata[294:231];
        thread_r            <= in_tdata[310:295];
        kind_r              <= in_tuser[6:3];
        {dst_ovf, dst_end}  <= {1'b0, in_tdata[63:0]} + {33'd0, in_tdata[159:128]};
        {src_ovf, src_end}  <= {1'b0, in_tdata[127:64]} + {33'd0, in_tdata[159:128]};
        uni                 <= '0;
        ev_valid            <= 1'b0;
        si                  <= '0;
      end
      OP_PREP: begin
        dst_last <= dst_end - 64'd1;
        src_last <= src_end - 64'd1;
      end
      OP_SLOT_NEXT: si <= si + 1'b1;
      OP_SW_START: begin
        k  <= lo_c;
        hi <= hi_c;
      end
      OP_ACC: begin
        uni <= uni | rdata;
        k   <= k + 1'b1;
      end
      OP_WR_ZERO: k <= (k == hi) ? '0 : k + 1'b1;
      OP_KINC:    k <= k + 1'b1;
      OP_EVENT:   ev_valid <= 1'b1;
      OP_CHUNK: begin
        clen    <= clen_c;
        clm1    <= OFFW'(clen_c - 1'b1);
        k       <= '0;
        si      <= '0;
        found   <= 1'b0;
        free_ok <= 1'b0;
      end
      OP_CHUNK_END: begin
        da  <= da + 64'(clen);
        sa  <= sa + 64'(clen);
        rem <= rem - 32'(clen);
      end
      OP_SEARCH_INIT: begin
        k       <= '0;
        si      <= '0;
        found   <= 1'b0;
        free_ok <= 1'b0;
      end
      OP_SEARCH_SRC, OP_SEARCH_DST: begin
        if (slot_valid[si] && slot_page[si] == key) begin
          found <= 1'b1;
          fidx  <= si;
        end
        if (!slot_valid[si] && !free_ok) begin
          free_ok <= 1'b1;
          freeidx <= si;
        end
        si <= si + 1'b1;
      end
      OP_TAKE_SRC: begin
        sp <= fidx;
        k  <= '0;
      end
      OP_TAKE_DST: begin
        dp <= found ? fidx : freeidx;
        if (!found && free_ok) slot_page[freeidx] <= da[63:OFFW];
        k  <= '0;
      end
      OP_RD_DST: sbyte <= rdata;
      OP_WR_MARK, OP_WR_PROP: k <= k + 1'b1;
      OP_OUT: begin
        out_tdata <= {1'b0, drops, 9'(events), 5'(pages),
                      ev_valid ? thread_r : 16'd0,
                      ev_valid ? instr_r : 64'd0,
                      ev_valid ? da : 64'd0,
                      ev_valid ? sink_addr_r : 64'd0,
                      ev_valid, uni, uni != '0};
        out_tuser <= ev_valid ? kind_r : 4'd0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/shadow_memory_taint_tracker.sv
// Top level of the byte-granular shadow memory taint tracker.
`default_nettype none
`include "shadow_memory_taint_tracker_macros.svh"
// Each item runs one command over a byte range and returns one result item with the
// current page, event and drop counts. The tag memory has one read and one write port,
// and the work per item follows from that: looking up a page walks every slot, walking
// the slots checks each one for overlap, query and sink checks read each byte of each
// overlapping page, mark reads and writes each byte plus a lookup per page, clear writes
// each byte of each touched page and then reads that page to test it for being clean,
// and propagate reads the source bytes, then reads and writes the destination bytes.
// After reset the tag memory, 2^ceil(log2(PAGE_SLOTS)) * PAGE_BYTES entries (65536 by
// default, two pages when there is a single slot), is cleared before the first item is
// accepted. A finished result waits in an output register.
module shadow_memory_taint_tracker import smtt_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int PAGE_SLOTS = PAGE_SLOTS_DEF,
  parameter int MAX_RANGE  = MAX_RANGE_DEF,
  parameter int MAX_EVENTS = MAX_EVENTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // addr, src_addr, size, tag, sink_address, instr_count, thread_id
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd, sink_type
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tainted, taint_union, event_valid, event_sink_address, event_data_address,
  // event_instr_count, event_thread, pages_in_use, events_recorded, drop_count
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // event_kind
  output logic      [OUT_TUSER_W-1:0] m_axis_tuser
);

  dp_op_t     op;
  dp_status_t st;

  smtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .op       (op)
  );

  smtt_dpath #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_SLOTS (PAGE_SLOTS),
    .MAX_RANGE  (MAX_RANGE),
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .st         (st),
    .in_tdata   (s_axis_tdata),
    .in_tuser   (s_axis_tuser),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser)
  );

  `SMTT_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SMTT_ASSERT_IMP(a_event_needs_taint, m_axis_tvalid && m_axis_tdata[8], m_axis_tdata[0])
  `SMTT_ASSERT_IMP(a_pages_bounded, m_axis_tvalid, m_axis_tdata[221:217] <= PAGE_SLOTS)
  `SMTT_ASSERT_IMP(a_events_bounded, m_axis_tvalid, m_axis_tdata[230:222] <= MAX_EVENTS)

endmodule
`default_nettype wire

>>> tb/shadow_memory_taint_tracker_tb.sv
// Self-checking testbench for the shadow memory taint tracker top level.
`timescale 1ns / 100ps
module shadow_memory_taint_tracker_tb;
  import smtt_pkg::*;

  localparam int PG = 4096;
  localparam int SLOTS = 16;
  localparam int RANGE_CAP = 4096;
  localparam int EVENT_CAP = 256;
  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd5;
  localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] addr;
    logic [63:0] src;
    logic [31:0] size;
    logic [6:0]  tag;
    logic [63:0] sink_pc;
    logic [63:0] icount;
    logic [15:0] thread;
    logic [3:0]  kind;
  } cmd_item_t;

  typedef struct {
    logic        tainted;
    logic [6:0]  tag_or;
    logic        ev_valid;
    logic [63:0] ev_pc;
    logic [63:0] ev_addr;
    logic [63:0] ev_icount;
    logic [15:0] ev_thread;
    logic [3:0]  ev_kind;
    logic [4:0]  pages;
    logic [8:0]  events;
    logic [63:0] drops;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  shadow_memory_taint_tracker dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  bit              slot_used[SLOTS];
  longint unsigned slot_page[SLOTS];
  bit [6:0]        shadow[SLOTS*PG];
  int unsigned     event_count;
  longint unsigned drop_total;
  report_t         expected_reports[$];
  int              errors;
  int              hold_cycles;
  int              idle_cycles;
  longint unsigned page_pool[24];

  function automatic void count_drop();
    if (drop_total != ALL_ONES) drop_total++;
  endfunction

  function automatic int lookup_page(longint unsigned pn);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_page[i] == pn) return i;
    return -1;
  endfunction

  function automatic int claim_page(longint unsigned pn);
    int i;
    i = lookup_page(pn);
    if (i >= 0) return i;
    for (i = 0; i < SLOTS; i++)
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_page[i] = pn;
        return i;
      end
    return -1;
  endfunction

  function automatic bit page_span(int s, longint unsigned a, longint unsigned last,
                                   output longint unsigned lo, output longint unsigned hi);
    longint unsigned pb, top;
    pb = slot_page[s] * PG;
    top = pb + PG - 1;
    if (pb > last || a > top) return 1'b0;
    lo = ((a > pb) ? a : pb) - pb;
    hi = ((last < top) ? last : top) - pb;
    return 1'b1;
  endfunction

  function automatic bit [6:0] range_tags(longint unsigned a, longint unsigned last);
    bit [6:0] u;
    longint unsigned lo, hi;
    u = 0;
    for (int s = 0; s < SLOTS; s++)
      if (slot_used[s] && page_span(s, a, last, lo, hi))
        for (longint unsigned k = lo; k <= hi; k++) u |= shadow[s*PG + k];
    return u;
  endfunction

  function automatic void apply_mark(longint unsigned a, longint unsigned n, bit [6:0] t);
    longint unsigned cur, stop, off, rem;
    int s;
    if (n == 0 || t == 0 || n > RANGE_CAP) return;
    if (n > ALL_ONES - a) begin
      count_drop();
      return;
    end
    cur = a;
    stop = a + n;
    while (cur < stop) begin
      off = cur % PG;
      rem = PG - off;
      if (rem > stop - cur) rem = stop - cur;
      s = claim_page(cur / PG);
      if (s < 0) return;
      for (longint unsigned k = 0; k < rem; k++) shadow[s*PG + off + k] |= t;
      cur += rem;
    end
  endfunction

  function automatic void apply_clear(longint unsigned a, longint unsigned n);
    longint unsigned lo, hi;
    bit clean;
    if (n == 0) return;
    if (n > ALL_ONES - a) begin
      count_drop();
      return;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (!slot_used[s] || !page_span(s, a, a + n - 1, lo, hi)) continue;
      for (longint unsigned k = lo; k <= hi; k++) shadow[s*PG + k] = 0;
      clean = 1'b1;
      for (int k = 0; k < PG; k++)
        if (shadow[s*PG + k] != 0) clean = 1'b0;
      if (clean) slot_used[s] = 1'b0;
    end
  endfunction

  function automatic void apply_propagate(longint unsigned dst, longint unsigned src,
                                          longint unsigned n);
    longint unsigned off, lo, hi, sa, da, so, dof, chunk;
    bit any, has;
    int sp, dp;
    if (n == 0 || n > RANGE_CAP) return;
    if (n > ALL_ONES - src || n > ALL_ONES - dst) begin
      count_drop();
      return;
    end
    any = 1'b0;
    for (int s = 0; s < SLOTS; s++)
      if (slot_used[s] && page_span(s, src, src + n - 1, lo, hi)) any = 1'b1;
    if (!any) return;
    off = 0;
    while (off < n) begin
      sa = src + off;
      da = dst + off;
      so = sa % PG;
      dof = da % PG;
      chunk = PG - so;
      if (PG - dof < chunk) chunk = PG - dof;
      if (n - off < chunk) chunk = n - off;
      sp = lookup_page(sa / PG);
      if (sp >= 0) begin
        has = 1'b0;
        for (longint unsigned k = 0; k < chunk; k++)
          if (shadow[sp*PG + so + k] != 0) has = 1'b1;
        if (has) begin
          dp = claim_page(da / PG);
          if (dp >= 0)
            for (longint unsigned k = 0; k < chunk; k++)
              shadow[dp*PG + dof + k] |= shadow[sp*PG + so + k];
        end
      end
      off += chunk;
    end
  endfunction

  function automatic report_t predict_report(cmd_item_t it);
    report_t r;
    bit [6:0] u;
    int pages;
    r = '{default: '0};
    case (it.cmd)
      CMD_MARK: apply_mark(it.addr, it.size, it.tag);
      CMD_CLEAR: apply_clear(it.addr, it.size);
      CMD_QUERY: begin
        if (it.size != 0 && it.size <= ALL_ONES - it.addr) begin
          u = range_tags(it.addr, it.addr + it.size - 1);
          r.tainted = (u != 0);
          r.tag_or = u;
        end
      end
      CMD_PROP: apply_propagate(it.addr, it.src, it.size);
      CMD_SINK: begin
        if (it.size != 0 && it.size <= RANGE_CAP) begin
          if (it.size > ALL_ONES - it.addr) begin
            count_drop();
          end else begin
            u = range_tags(it.addr, it.addr + it.size - 1);
            if (u != 0) begin
              r.tainted = 1'b1;
              r.tag_or = u;
              if (event_count < EVENT_CAP) begin
                event_count++;
                r.ev_valid = 1'b1;
                r.ev_pc = it.sink_pc;
                r.ev_addr = it.addr;
                r.ev_icount = it.icount;
                r.ev_thread = it.thread;
                r.ev_kind = it.kind;
              end else begin
                count_drop();
              end
            end
          end
        end
      end
      default: ;
    endcase
    pages = 0;
    for (int s = 0; s < SLOTS; s++) pages += slot_used[s];
    r.pages = pages[4:0];
    r.events = event_count[8:0];
    r.drops = drop_total;
    return r;
  endfunction

  task automatic send_item(cmd_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, it.thread, it.icount, it.sink_pc, it.tag, it.size, it.src, it.addr};
    s_axis_tuser <= {it.kind, it.cmd};
    do @(posedge clk); while (!s_axis_tready);
    expected_reports = {expected_reports, predict_report(it)};
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  function automatic cmd_item_t make_item(logic [2:0] c, logic [63:0] a, logic [31:0] n,
                                          logic [6:0] t, logic [63:0] src);
    cmd_item_t it;
    it.cmd = c;
    it.addr = a;
    it.src = src;
    it.size = n;
    it.tag = t;
    it.sink_pc = {$urandom, $urandom};
    it.icount = {$urandom, $urandom};
    it.thread = 16'($urandom);
    it.kind = 4'($urandom);
    return it;
  endfunction

  function automatic logic [63:0] pool_addr();
    logic [63:0] a;
    a = page_pool[$urandom_range(0, 23)] * PG + $urandom_range(0, PG - 1);
    if ($urandom_range(0, 3) == 0) a = a & ~64'hFFF | {$urandom_range(0, 1) ? 12'hFC0 : 12'h000}
                                       | $urandom_range(0, 63);
    return a;
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return $urandom;
    if (r < 3) return $urandom_range(RANGE_CAP - 2, RANGE_CAP + 2);
    if (r < 8) return $urandom_range(64, 1024);
    if (r < 12) return 0;
    return $urandom_range(1, 64);
  endfunction

  function automatic cmd_item_t random_item();
    int r;
    logic [2:0] c;
    logic [63:0] a, src;
    r = $urandom_range(0, 99);
    if (r < 30) c = CMD_MARK;
    else if (r < 42) c = CMD_CLEAR;
    else if (r < 56) c = CMD_QUERY;
    else if (r < 74) c = CMD_PROP;
    else if (r < 97) c = CMD_SINK;
    else c = 3'($urandom_range(CMD_UNKNOWN, 7));
    a = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : pool_addr();
    src = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : pool_addr();
    return make_item(c, a, pick_size(), ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom),
                     src);
  endfunction

  task automatic test_directed();
    send_item(make_item(CMD_QUERY, 64'h0, 32'd16, 7'd0, 64'h0));
    send_item(make_item(CMD_MARK, 64'h10, 32'd8, 7'h7F, 64'h0));
    send_item(make_item(CMD_MARK, 64'h12, 32'd1, 7'h01, 64'h0));
    send_item(make_item(CMD_MARK, 64'h20, 32'd4, 7'd0, 64'h0));
    send_item(make_item(CMD_MARK, 64'h30, 32'd0, 7'h05, 64'h0));
    send_item(make_item(CMD_MARK, 64'h40, RANGE_CAP + 1, 7'h05, 64'h0));
    send_item(make_item(CMD_QUERY, 64'h0, 32'd4096, 7'd0, 64'h0));
    send_item(make_item(CMD_QUERY, 64'h12, 32'd1, 7'd0, 64'h0));
    send_item(make_item(CMD_MARK, 64'hFF8, 32'd16, 7'h40, 64'h0));
    send_item(make_item(CMD_PROP, 64'h2FFC, 32'd32, 7'd0, 64'hFF0));
    send_item(make_item(CMD_PROP, 64'h14, 32'd8, 7'd0, 64'h10));
    send_item(make_item(CMD_QUERY, 64'h2FF0, 32'd64, 7'd0, 64'h0));
    send_item(make_item(CMD_SINK, 64'h10, 32'd4, 7'd0, 64'h0));
    send_item(make_item(CMD_SINK, 64'h500, 32'd4, 7'd0, 64'h0));
    send_item(make_item(CMD_SINK, 64'h10, RANGE_CAP + 1, 7'd0, 64'h0));
    send_item(make_item(CMD_MARK, ALL_ONES - 3, 32'd4, 7'h22, 64'h0));
    send_item(make_item(CMD_QUERY, ALL_ONES, 32'd1, 7'd0, 64'h0));
    send_item(make_item(CMD_MARK, ALL_ONES, 32'd2, 7'h22, 64'h0));
    send_item(make_item(CMD_CLEAR, ALL_ONES - 1, 32'd3, 7'd0, 64'h0));
    send_item(make_item(CMD_PROP, 64'h0, 32'd4, 7'd0, ALL_ONES - 1));
    send_item(make_item(CMD_SINK, ALL_ONES, 32'd2, 7'd0, 64'h0));
    send_item(make_item(CMD_QUERY, ALL_ONES, 32'hFFFF_FFFF, 7'd0, 64'h0));
    send_item(make_item(CMD_UNKNOWN, 64'h10, 32'd4, 7'h7F, 64'h0));
    send_item(make_item(3'd7, 64'h10, 32'd4, 7'h7F, 64'h0));
    send_item(make_item(CMD_CLEAR, 64'h0, 32'd12288, 7'd0, 64'h0));
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    for (int i = 0; i < 40; i++) send_item(random_item());
    drain_results();
  endtask

  task automatic test_random();
    int sent, burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) send_item(random_item());
      sent += burst;
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) drain_results();
      else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
    end
    drain_results();
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    report_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none, actual %0h", $time,
                 m_axis_tdata);
      end else begin
        e = expected_reports.pop_front();
        check_field("tainted", e.tainted, m_axis_tdata[0]);
        check_field("taint_union", e.tag_or, m_axis_tdata[7:1]);
        check_field("event_valid", e.ev_valid, m_axis_tdata[8]);
        check_field("event_sink_address", e.ev_pc, m_axis_tdata[72:9]);
        check_field("event_data_address", e.ev_addr, m_axis_tdata[136:73]);
        check_field("event_instr_count", e.ev_icount, m_axis_tdata[200:137]);
        check_field("event_thread", e.ev_thread, m_axis_tdata[216:201]);
        check_field("pages_in_use", e.pages, m_axis_tdata[221:217]);
        check_field("events_recorded", e.events, m_axis_tdata[230:222]);
        check_field("drop_count", e.drops, m_axis_tdata[294:231]);
        check_field("event_kind", e.ev_kind, m_axis_tuser);
      end
    end
  end

  always @(posedge clk) begin
    int phase;
    phase = int'($time / 640 % 4);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (phase == 0) begin
      m_axis_tready <= 1'b1;
    end else if (phase == 1) begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("shadow_memory_taint_tracker_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    hold_cycles = 0;
    idle_cycles = 0;
    event_count = 0;
    drop_total = 0;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < SLOTS*PG; i++) shadow[i] = 0;
    for (int i = 0; i < 20; i++) page_pool[i] = i;
    page_pool[20] = 64'h000F_FFFF_FFFF_FFFF;
    page_pool[21] = 64'h000F_FFFF_FFFF_FFFE;
    page_pool[22] = 64'h0000_0000_0001_2345;
    page_pool[23] = 64'h0000_8000_0000_0000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("shadow_memory_taint_tracker_tb passed");
    end else begin
      $display("shadow_memory_taint_tracker_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/smtt_pkg.sv
hdl/smtt_ram.sv
hdl/smtt_ctrl.sv
hdl/smtt_dpath.sv
hdl/shadow_memory_taint_tracker.sv
tb/shadow_memory_taint_tracker_tb.sv
